// ===== rtl/bpcl_pkg.sv =====
// Package for the button press code lock: register map, widths and shared helpers.
package bpcl_pkg;

  // Field widths
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned TIMER_W   = 19;
  localparam int unsigned WIN_MS_W  = 18;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned DIGIT_W   = 2;

  // Stream and APB widths
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned APB_ADDR_W  = 5;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [WIN_MS_W-1:0] MS_PER_SECOND = WIN_MS_W'(1000);
  localparam logic [COUNT_W-1:0]  COUNT_MAX     = '1;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_ENABLE       = 3'd0,
    REG_DIGIT_COUNT  = 3'd1,
    REG_WINDOW_SEC   = 3'd2,
    REG_FIRST_DIGIT  = 3'd3,
    REG_SECOND_DIGIT = 3'd4,
    REG_THIRD_DIGIT  = 3'd5
  } cfg_reg_t;

  // Result bit positions inside out_tdata
  localparam int unsigned OUT_POWER_ON = 0;
  localparam int unsigned OUT_BLUE     = 1;
  localparam int unsigned OUT_GREEN    = 2;
  localparam int unsigned OUT_ENTERING = 3;

  // Result flags of one tick
  typedef struct packed {
    logic entering_code;
    logic blink_green;
    logic blink_blue;
    logic power_on;
  } result_t;

endpackage

// ===== rtl/button_press_code_lock_unit.sv =====
// Top level of the button press code lock: APB registers, tick stream in, result stream out.
//
//  channel   | ports                            | payload
//  ----------+----------------------------------+--------------------------------------
//  in        | in_tvalid/in_tready/in_tdata     | [0] button_level, [16:1] elapsed_ms
//  out       | out_tvalid/out_tready/out_tdata  | [0] power_on, [1] blink_blue,
//            |                                  | [2] blink_green, [3] entering_code
//  cfg       | cfg_psel/penable/pwrite/paddr/.. | six registers at byte addresses 0..20
//
// One tick per cycle sustained while out_tready is high; a tick passes through the input
// register, then the lock update into the result register.
// rst_n is synchronous and active low; it resets lock state, valids and registers.
// A full result register that is not taken stalls the input register, which then
// drops in_tready; both stages move together when out_tready is high.
module button_press_code_lock_unit
  import bpcl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // tick stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] button_level, [16:1] elapsed_ms, rest 0
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] power_on, [1] blink_blue,
                                             // [2] blink_green, [3] entering_code, rest 0
  // configuration
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [APB_DATA_W-1:0]  cfg_pwdata,
  output logic [APB_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  // Configuration registers
  logic                enable_r;
  logic [DIGIT_W-1:0]  digit_count_r;
  logic [7:0]          window_sec_r;
  logic [WIN_MS_W-1:0] window_ms_r;
  logic [COUNT_W-1:0]  first_digit_r;
  logic [COUNT_W-1:0]  second_digit_r;
  logic [COUNT_W-1:0]  third_digit_r;
  logic                cfg_wr;
  cfg_reg_t            cfg_idx;

  // Input stage
  logic                 in_valid_r;
  logic                 level_r;
  logic [ELAPSED_W-1:0] elapsed_r;

  // Lock state
  logic                was_pressed_r, was_pressed_nxt;
  logic                watching_r,    watching_nxt;
  logic [TIMER_W-1:0]  timer_r,       timer_nxt;
  logic [COUNT_W-1:0]  count_r,       count_nxt;
  logic [DIGIT_W-1:0]  digit_idx_r,   digit_idx_nxt;

  // Result stage
  logic                out_valid_r;
  result_t             result_r, result_nxt;

  logic                advance;
  logic                released;
  logic [TIMER_W-1:0]  timer_sum;
  logic [COUNT_W-1:0]  count_inc;
  logic [COUNT_W-1:0]  required;
  logic                expired;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[4:2]);

  // Register writes; window also kept in milliseconds for the expiry compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      digit_count_r  <= '0;
      window_sec_r   <= 8'd1;
      window_ms_r    <= MS_PER_SECOND;
      first_digit_r  <= '0;
      second_digit_r <= '0;
      third_digit_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE:       enable_r       <= cfg_pwdata[0];
        REG_DIGIT_COUNT:  digit_count_r  <= cfg_pwdata[DIGIT_W-1:0];
        REG_WINDOW_SEC: begin
          window_sec_r <= cfg_pwdata[7:0];
          window_ms_r  <= WIN_MS_W'(cfg_pwdata[7:0]) * MS_PER_SECOND;
        end
        REG_FIRST_DIGIT:  first_digit_r  <= cfg_pwdata[COUNT_W-1:0];
        REG_SECOND_DIGIT: second_digit_r <= cfg_pwdata[COUNT_W-1:0];
        REG_THIRD_DIGIT:  third_digit_r  <= cfg_pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_ENABLE:       cfg_prdata = APB_DATA_W'(enable_r);
      REG_DIGIT_COUNT:  cfg_prdata = APB_DATA_W'(digit_count_r);
      REG_WINDOW_SEC:   cfg_prdata = APB_DATA_W'(window_sec_r);
      REG_FIRST_DIGIT:  cfg_prdata = APB_DATA_W'(first_digit_r);
      REG_SECOND_DIGIT: cfg_prdata = APB_DATA_W'(second_digit_r);
      REG_THIRD_DIGIT:  cfg_prdata = APB_DATA_W'(third_digit_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Pipeline flow: result register frees up, input stage moves into it
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      level_r   <= in_tdata[0];
      elapsed_r <= in_tdata[ELAPSED_W:1];
    end
  end

  // Code digit for the current index; index zero wants zero releases
  always_comb begin
    unique case (digit_idx_r)
      2'd1:    required = first_digit_r;
      2'd2:    required = second_digit_r;
      2'd3:    required = third_digit_r;
      default: required = '0;
    endcase
  end

  assign released  = was_pressed_r & ~level_r;
  assign timer_sum = timer_r + TIMER_W'(elapsed_r);
  assign count_inc = (released && count_r != COUNT_MAX) ? count_r + COUNT_W'(1) : count_r;
  assign expired   = timer_sum > TIMER_W'(window_ms_r);

  // Lock update for one tick
  always_comb begin
    was_pressed_nxt = was_pressed_r;
    watching_nxt    = watching_r;
    timer_nxt       = timer_r;
    count_nxt       = count_r;
    digit_idx_nxt   = digit_idx_r;
    result_nxt      = '0;

    if (enable_r) begin
      was_pressed_nxt = level_r;
      if (watching_r) begin
        count_nxt = count_inc;
        if (expired) begin
          timer_nxt = '0;
          if (count_inc == required) begin
            if (digit_idx_r == digit_count_r) begin
              // last digit matched
              result_nxt.power_on = 1'b1;
              watching_nxt        = 1'b0;
            end else begin
              // digit matched, move on; the count restarts at zero for the next digit
              digit_idx_nxt         = digit_idx_r + DIGIT_W'(1);
              count_nxt             = '0;
              result_nxt.blink_blue = 1'b1;
            end
          end else begin
            watching_nxt = 1'b0;
          end
        end else begin
          timer_nxt = timer_sum;
        end
      end else if (released) begin
        if (digit_count_r != '0) begin
          // first release opens entry and counts as one
          watching_nxt  = 1'b1;
          count_nxt     = COUNT_W'(1);
          timer_nxt     = '0;
          digit_idx_nxt = DIGIT_W'(1);
        end else begin
          result_nxt.power_on    = 1'b1;
          result_nxt.blink_green = 1'b1;
        end
      end
    end
    result_nxt.entering_code = watching_nxt;
  end

  // Lock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_pressed_r <= 1'b0;
      watching_r    <= 1'b0;
      timer_r       <= '0;
      count_r       <= '0;
      digit_idx_r   <= DIGIT_W'(1);
    end else if (advance) begin
      was_pressed_r <= was_pressed_nxt;
      watching_r    <= watching_nxt;
      timer_r       <= timer_nxt;
      count_r       <= count_nxt;
      digit_idx_r   <= digit_idx_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (~out_valid_r | out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(result_r);

endmodule

// ===== rtl/bpcl_checker.sv =====
// Port-level checker for the button press code lock, bound to the top level.
module bpcl_checker
  import bpcl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result transaction holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Green blink only comes with power on, and entry is then closed
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_GREEN] |->
      out_tdata[OUT_POWER_ON] && !out_tdata[OUT_ENTERING])
    else $error("green blink without power on");

  // Blue blink means entry continues and no power on yet
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_BLUE] |->
      out_tdata[OUT_ENTERING] && !out_tdata[OUT_POWER_ON])
    else $error("blue blink outside code entry");

  // Power on always ends code entry
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_POWER_ON] |-> !out_tdata[OUT_ENTERING])
    else $error("power on while still entering code");

  // A result needs an earlier accepted tick: none right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind button_press_code_lock_unit bpcl_checker u_bpcl_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the button press code lock: tick stream in, flag stream out.
module tb;
  import bpcl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 800_000;
  localparam int          RANDOM_TICKS = 1800;

  // One pending tick transaction with the idle cycles that follow it
  typedef struct {
    logic        level;
    logic [15:0] elapsed;
    int          gap;
    bit          drain;
  } tick_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [0] button_level, [16:1] elapsed_ms, rest 0
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [0] power_on, [1] blink_blue,
                                           // [2] blink_green, [3] entering_code, rest 0
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  cfg_paddr = '0;
  logic [APB_DATA_W-1:0]  cfg_pwdata = '0;
  logic [APB_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  button_press_code_lock_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the lock registers and state
  logic                cf_enable = 1'b0;
  logic [DIGIT_W-1:0]  cf_digits = '0;
  logic [7:0]          cf_window = 8'd1;
  logic [COUNT_W-1:0]  cf_code [0:3] = '{default: '0};   // entry 0 stays zero
  logic                lk_was_pressed = 1'b0;
  logic                lk_watching = 1'b0;
  logic [TIMER_W-1:0]  lk_timer = '0;
  logic [COUNT_W-1:0]  lk_count = '0;
  logic [DIGIT_W-1:0]  lk_digit = 2'd1;

  tick_t   ticks_pending[$];
  result_t flags_due[$];
  int      ticks_queued = 0;
  int      live_ticks = 0;
  int      ticks_taken = 0;
  int      flags_seen = 0;
  int      fail_cnt = 0;
  int      in_gap = 0;
  int      out_hold = 0;
  bit      in_calm = 1'b0;
  bit      out_calm = 1'b0;
  int      win_lim;
  int      win_acc;

  // Flags one tick produces; advances the shadow state
  function automatic result_t predict_lock_flags(input logic level, input logic [15:0] elapsed);
    result_t r;
    logic    released;
    r = '0;
    if (cf_enable) begin
      released = lk_was_pressed && !level;
      if (lk_watching) begin
        lk_timer = lk_timer + TIMER_W'(elapsed);
        if (released && lk_count != 8'hFF) lk_count = lk_count + 8'd1;
        if (int'(lk_timer) > int'(cf_window) * 1000) begin
          lk_timer = '0;
          if (lk_count == cf_code[lk_digit]) begin
            if (lk_digit == cf_digits) begin
              r.power_on  = 1'b1;
              lk_watching = 1'b0;
            end else begin
              lk_digit     = lk_digit + 2'd1;
              lk_count     = '0;
              r.blink_blue = 1'b1;
            end
          end else begin
            lk_watching = 1'b0;
          end
        end
      end else if (released) begin
        if (cf_digits != 0) begin
          lk_watching = 1'b1;
          lk_count    = 8'd1;
          lk_timer    = '0;
          lk_digit    = 2'd1;
        end else begin
          r.power_on    = 1'b1;
          r.blink_green = 1'b1;
        end
      end
      lk_was_pressed = level;
    end
    r.entering_code = lk_watching;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Driver: tick stream, gap after each transaction, optional hold until drained
  always @(posedge clk) begin : tick_driver
    tick_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (ticks_pending.size() != 0 &&
                   !(ticks_pending[0].drain && (in_tvalid || ticks_taken != flags_seen))) begin
        nxt = ticks_pending.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {7'b0, nxt.elapsed, nxt.level};
        in_gap    <= nxt.gap;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin : flag_ready
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b1;
      out_hold   <= 0;
    end else if (out_tvalid && out_tready) begin
      stall = out_calm ? 0 : $urandom_range(0, 12);
      out_tready <= (stall == 0);
      out_hold   <= stall;
    end else if (!out_tready) begin
      if (out_hold <= 1) out_tready <= 1'b1;
      out_hold <= out_hold - 1;
    end
  end

  // Monitor: check results against the oldest expectation, predict on each accepted tick
  always @(posedge clk) begin : flag_monitor
    result_t want;
    result_t seen;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        flags_seen <= flags_seen + 1;
        seen = out_tdata[3:0];
        if (flags_due.size() == 0) begin
          $error("result transaction with nothing expected: %h", out_tdata);
          fail_cnt++;
        end else begin
          want = flags_due.pop_front();
          check_field("power_on", want.power_on, seen.power_on);
          check_field("blink_blue", want.blink_blue, seen.blink_blue);
          check_field("blink_green", want.blink_green, seen.blink_green);
          check_field("entering_code", want.entering_code, seen.entering_code);
        end
        check_field("tdata padding", 0, int'(out_tdata[OUT_TDATA_W-1:4]));
      end
      if (in_tvalid && in_tready) begin
        ticks_taken <= ticks_taken + 1;
        flags_due.push_back(predict_lock_flags(in_tdata[0], in_tdata[16:1]));
      end
    end
  end

  // APB write; junk above the field width now and then
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] field);
    logic [31:0] mask;
    logic [31:0] word;
    case (idx)
      REG_ENABLE:      mask = 32'h1;
      REG_DIGIT_COUNT: mask = 32'h3;
      default:         mask = 32'hFF;
    endcase
    word = field & mask;
    if ($urandom_range(0, 3) == 0) word = word | ($urandom & ~mask);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_ENABLE:       cf_enable = word[0];
      REG_DIGIT_COUNT:  cf_digits = word[1:0];
      REG_WINDOW_SEC:   cf_window = word[7:0];
      REG_FIRST_DIGIT:  cf_code[1] = word[7:0];
      REG_SECOND_DIGIT: cf_code[2] = word[7:0];
      REG_THIRD_DIGIT:  cf_code[3] = word[7:0];
      default: ;
    endcase
  endtask

  task automatic add_tick(input logic level, input int elapsed, input bit drain);
    tick_t t;
    t.level   = level;
    t.elapsed = 16'(elapsed);
    t.gap     = in_calm ? 0 : $urandom_range(0, 12);
    t.drain   = drain || ($urandom_range(0, 149) == 0);
    ticks_pending.push_back(t);
    ticks_queued++;
    if (cf_enable) live_ticks++;
  endtask

  task automatic wait_drained();
    while (flags_seen != ticks_queued) @(posedge clk);
  endtask

  function automatic int any_elapsed();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(0, 65535);
      2:       return $urandom_range(0, 50);
      default: return ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(0, 1500);
    endcase
  endfunction

  // Elapsed time that keeps the entry window open
  function automatic int open_elapsed();
    int room;
    int el;
    room = win_lim - win_acc;
    el   = (room <= 0) ? 0 : $urandom_range(0, (room < 30) ? room : 30);
    win_acc += el;
    return el;
  endfunction

  // Idle-level ticks until the window runs out
  task automatic expire_window();
    int el;
    while (win_acc <= win_lim) begin
      el = win_lim - win_acc + 1 + $urandom_range(0, 20);
      if (el > 65535) el = 65535;
      add_tick(1'b0, el, 1'b0);
      win_acc += el;
    end
    win_acc = 0;
  endtask

  task automatic flush_lock(input int reps);
    win_lim = int'(cf_window) * 1000;
    win_acc = 0;
    repeat (reps) expire_window();
  endtask

  // Code entry: starting release, then releases per digit and a window expiry each
  task automatic gen_entry(input int adjust, input int upto);
    int n;
    win_lim = int'(cf_window) * 1000;
    win_acc = 0;
    add_tick(1'b1, any_elapsed(), 1'b0);
    add_tick(1'b0, any_elapsed(), 1'b0);
    for (int k = 1; k <= upto; k++) begin
      n = int'(cf_code[k]) - ((k == 1) ? 1 : 0);
      if (k == 1) n += adjust;
      else if ($urandom_range(0, 7) == 0) n += ($urandom_range(0, 1) != 0) ? 1 : -1;
      win_acc = 0;
      for (int i = 0; i < n; i++) begin
        add_tick(1'b1, open_elapsed(), 1'b0);
        if (i == n - 1 && $urandom_range(0, 3) == 0) begin
          // last release lands on the expiry tick
          add_tick(1'b0, (win_lim - win_acc + 1 > 65535) ? 65535 : win_lim - win_acc + 1,
                   1'b0);
          win_acc += (win_lim - win_acc + 1 > 65535) ? 65535 : win_lim - win_acc + 1;
        end else begin
          add_tick(1'b0, open_elapsed(), 1'b0);
        end
      end
      expire_window();
    end
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(4, 24)) add_tick(1'($urandom_range(0, 1)), any_elapsed(), 1'b0);
    flush_lock(6);
  endtask

  function automatic int pick_window();
    int r;
    r = $urandom_range(0, 19);
    if (r <= 10) return $urandom_range(0, 2);
    if (r <= 15) return $urandom_range(3, 20);
    if (r == 16) return 0;
    if (r == 17) return 255;
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_digit();
    int r;
    r = $urandom_range(0, 49);
    if (r == 0) return 255;
    if (r == 1) return $urandom_range(0, 255);
    return $urandom_range(0, 4);
  endfunction

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus sequencing
  initial begin : stimulus
    bit sat;
    bit carry;
    int goal;
    carry = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled after reset: ticks ignored
    add_tick(1'b1, 65535, 1'b0);
    add_tick(1'b0, 0, 1'b0);
    wait_drained();

    // No code set: release powers on at once
    write_reg(REG_ENABLE, 1);
    write_reg(REG_DIGIT_COUNT, 0);
    write_reg(REG_WINDOW_SEC, 1);
    add_tick(1'b1, 0, 1'b0);
    add_tick(1'b0, 0, 1'b0);
    wait_drained();

    // Zero window; a release on an expiry tick completes the first digit; the last digit
    // is also completed by a release on the expiry tick
    write_reg(REG_DIGIT_COUNT, 3);
    write_reg(REG_WINDOW_SEC, 0);
    write_reg(REG_FIRST_DIGIT, 2);
    write_reg(REG_SECOND_DIGIT, 0);
    write_reg(REG_THIRD_DIGIT, 2);
    add_tick(1'b1, 0, 1'b0);
    add_tick(1'b0, 0, 1'b0);
    add_tick(1'b1, 0, 1'b0);
    add_tick(1'b0, 1, 1'b0);
    add_tick(1'b0, 1, 1'b0);
    add_tick(1'b1, 0, 1'b0);
    add_tick(1'b0, 0, 1'b0);
    add_tick(1'b1, 0, 1'b0);
    add_tick(1'b0, 1, 1'b0);
    wait_drained();

    // Widest window with full-scale elapsed; stays in entry at digit one
    write_reg(REG_WINDOW_SEC, 255);
    add_tick(1'b1, 0, 1'b1);
    add_tick(1'b0, 65535, 1'b0);
    add_tick(1'b1, 65535, 1'b0);
    add_tick(1'b0, 65535, 1'b0);
    add_tick(1'b0, 65535, 1'b0);
    wait_drained();

    // Disabled mid-entry keeps the watching flag
    write_reg(REG_ENABLE, 0);
    add_tick(1'b1, 65535, 1'b0);
    wait_drained();

    // Digit count lowered during entry: the pending first digit now matches as the last and powers on
    write_reg(REG_ENABLE, 1);
    write_reg(REG_DIGIT_COUNT, 1);
    write_reg(REG_WINDOW_SEC, 0);
    write_reg(REG_THIRD_DIGIT, 0);
    repeat (4) add_tick(1'b0, 1, 1'b0);
    wait_drained();

    // Random phases
    while (live_ticks < RANDOM_TICKS) begin
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      sat      = ($urandom_range(0, 11) == 0);
      write_reg(REG_ENABLE, 32'($urandom_range(0, 9) != 0));
      write_reg(REG_DIGIT_COUNT, sat ? $urandom_range(1, 3) : $urandom_range(0, 3));
      write_reg(REG_WINDOW_SEC, pick_window());
      write_reg(REG_FIRST_DIGIT, sat ? 255 : pick_digit());
      write_reg(REG_SECOND_DIGIT, pick_digit());
      write_reg(REG_THIRD_DIGIT, pick_digit());
      if (!carry) flush_lock(6);
      carry = 1'b0;
      goal  = ticks_queued + $urandom_range(40, 140);
      // release count driven into saturation
      if (sat) gen_entry($urandom_range(0, 4), int'(cf_digits));
      while (ticks_queued < goal) begin
        if ($urandom_range(0, 9) < 7) begin
          gen_entry(($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0) ? 1 : -1) : 0,
                    int'(cf_digits));
        end else begin
          gen_noise();
        end
      end
      // leave an entry open across the next register change
      if ($urandom_range(0, 3) == 0 && cf_digits > 1) begin
        flush_lock(6);
        gen_entry(0, $urandom_range(1, int'(cf_digits) - 1));
        carry = 1'b1;
      end
      wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && flags_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bpcl_pkg.sv
rtl/button_press_code_lock_unit.sv
rtl/bpcl_checker.sv
test/tb.sv
